// ----- design/dslpc_pkg.sv -----
package dslpc_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int CFG_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int COLUMN_BITS        = 3;
   localparam int COUNT_BITS_DEFAULT = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_TICKS = 2'd1;

   // Reset values of the registers and of the column state.
   localparam logic [CFG_BITS-1:0]    DEBOUNCE_TICKS_RESET   = 16'd50;
   localparam logic [CFG_BITS-1:0]    LONG_PRESS_TICKS_RESET = 16'd1000;
   localparam logic [COLUMN_BITS-1:0] SHORT_COLUMN_RESET     = 3'd2;
   localparam logic [COLUMN_BITS-1:0] LONG_COLUMN_RESET      = 3'd4;

   // Event codes carried with every result item.
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } event_kind_type;

   // Configuration register contents.
   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ticks;
      logic [CFG_BITS-1:0] long_press_ticks;
   } cfg_type;

   // One result item as produced by the core.
   typedef struct packed {
      event_kind_type         event_kind;
      logic [COLUMN_BITS-1:0] column_number;
      logic [COLUMN_BITS-1:0] color_index;
      logic                   led_level;
      logic                   debounced_level;
   } result_type;

endpackage

// ----- design/dslpc_csr.sv -----
module dslpc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [dslpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dslpc_pkg::CFG_BITS-1:0]        csr_data,
   output dslpc_pkg::cfg_type                    cfg
);
   import dslpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes beyond the map are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_data;
            CSR_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_TICKS_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/dslpc_core.sv -----
module dslpc_core #(
   parameter int COUNT_BITS = dslpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   raw_level,
   input  dslpc_pkg::cfg_type     cfg,
   output dslpc_pkg::result_type  result
);
   import dslpc_pkg::*;

   // Compare width covers both the counters and the 16-bit registers.
   localparam int CmpW = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   logic                   prev_raw_ff, prev_raw_in;
   logic                   stable_level_ff, stable_level_in;
   logic [COUNT_BITS-1:0]  stable_count_ff, stable_count_in;
   logic [COUNT_BITS-1:0]  press_count_ff, press_count_in;
   logic                   long_seen_ff, long_seen_in;
   logic [COLUMN_BITS-1:0] short_column_ff, short_column_in;
   logic [COLUMN_BITS-1:0] long_column_ff, long_column_in;
   logic                   led_ff, led_in;

   logic [COUNT_BITS-1:0]  press_inc;
   logic [CmpW-1:0]        stable_ext, debounce_ext, press_inc_ext, press_new_ext, long_ext;
   logic                   level_change, press_start, short_hit, long_hit, long_seen_mid;
   logic [COUNT_BITS-1:0]  press_new;

   // One tick of debounce and press timing.
   always_comb begin
      stable_count_in = (raw_level != prev_raw_ff) ? '0 :
                        (&stable_count_ff) ? stable_count_ff : stable_count_ff + 1'b1;
      press_inc       = (&press_count_ff) ? press_count_ff : press_count_ff + 1'b1;

      stable_ext    = CmpW'(stable_count_in);
      debounce_ext  = CmpW'(cfg.debounce_ticks);
      press_inc_ext = CmpW'(press_inc);
      long_ext      = CmpW'(cfg.long_press_ticks);

      level_change    = (stable_ext > debounce_ext) && (raw_level != stable_level_ff);
      press_start     = level_change && !raw_level;
      stable_level_in = level_change ? raw_level : stable_level_ff;
      press_new       = press_start ? '0 : press_inc;
      press_new_ext   = CmpW'(press_new);
      long_seen_mid   = press_start ? 1'b0 : long_seen_ff;

      // A release before the long time is a short press.
      short_hit = level_change && raw_level && !long_seen_ff && (press_inc_ext < long_ext);
      // Holding past the long time is reported once per press.
      long_hit  = !stable_level_in && (press_new_ext >= long_ext) && !long_seen_mid;

      press_count_in  = press_new;
      long_seen_in    = long_seen_mid | long_hit;
      short_column_in = short_hit ? (short_column_ff ^ 3'd1) : short_column_ff;
      long_column_in  = long_hit ? (long_column_ff ^ 3'd1) : long_column_ff;
      led_in          = long_hit ? 1'b0 : (short_hit ? 1'b1 : led_ff);
      prev_raw_in     = raw_level;

      result.led_level       = led_in;
      result.debounced_level = stable_level_in;
      if (long_hit) begin
         result.event_kind    = EV_LONG;
         result.column_number = long_column_ff;
         result.color_index   = long_column_in;
      end else if (short_hit) begin
         result.event_kind    = EV_SHORT;
         result.column_number = short_column_ff;
         result.color_index   = short_column_in;
      end else begin
         result.event_kind    = EV_NONE;
         result.column_number = '0;
         result.color_index   = '0;
      end
   end

   // State advances only when an item passes through.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff     <= 1'b1;
         stable_level_ff <= 1'b1;
         stable_count_ff <= '0;
         press_count_ff  <= '0;
         long_seen_ff    <= 1'b0;
         short_column_ff <= SHORT_COLUMN_RESET;
         long_column_ff  <= LONG_COLUMN_RESET;
         led_ff          <= 1'b0;
      end else if (step_en) begin
         prev_raw_ff     <= prev_raw_in;
         stable_level_ff <= stable_level_in;
         stable_count_ff <= stable_count_in;
         press_count_ff  <= press_count_in;
         long_seen_ff    <= long_seen_in;
         short_column_ff <= short_column_in;
         long_column_ff  <= long_column_in;
         led_ff          <= led_in;
      end
   end

endmodule

// ----- design/debounced_short_long_press_classifier.sv -----
// Channel  Ports                                   Direction  Accept
// req      req_valid req_ready req_raw_level       in         valid & ready
// rsp      rsp_valid rsp_ready rsp_<result fields>  out        valid & ready
// csr      csr_valid csr_ready csr_index csr_data  in         valid & ready
//
// Each tick item passes through the input register, then through the press
// logic into the result register. One item per cycle is sustained while the
// result side accepts; the core's state update is a single pass.
// Synchronous reset restores the register defaults and the released state.
// A stalled result holds the core; the input register still takes one item.
module debounced_short_long_press_classifier #(
   parameter int COUNT_BITS = dslpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_raw_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_event_kind,
   output logic [dslpc_pkg::COLUMN_BITS-1:0]     rsp_column_number,
   output logic [dslpc_pkg::COLUMN_BITS-1:0]     rsp_color_index,
   output logic                                  rsp_led_level,
   output logic                                  rsp_debounced_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dslpc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dslpc_pkg::CFG_BITS-1:0]        csr_data
);
   import dslpc_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_raw_ff, in_raw_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       step_en;

   assign csr_ready = 1'b1;

   dslpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The core steps when an item waits and the result register can take it.
   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step_en);
      in_raw_in    = (req_valid && req_ready) ? req_raw_level : in_raw_ff;
      rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);
   end

   dslpc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .raw_level (in_raw_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // Handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_raw_ff <= in_raw_in;
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_ff.event_kind;
   assign rsp_column_number   = rsp_ff.column_number;
   assign rsp_color_index     = rsp_ff.color_index;
   assign rsp_led_level       = rsp_ff.led_level;
   assign rsp_debounced_level = rsp_ff.debounced_level;

   // A short press is reported on release and lights the LED.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_SHORT) |-> (rsp_led_level && rsp_debounced_level))
      else $error("short item without LED on and switch released");

   // A long press is reported while held and turns the LED off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_LONG) |-> (!rsp_led_level && !rsp_debounced_level))
      else $error("long item without LED off and switch held");

   // The color index is the column after its toggle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_NONE) |-> (rsp_color_index == (rsp_column_number ^ 3'd1)))
      else $error("color index does not follow column toggle");

   // Items without an event carry zero column and color.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_NONE) |-> (rsp_column_number == '0 && rsp_color_index == '0))
      else $error("column or color set on an item without event");

endmodule

// ----- verif/debounced_short_long_press_classifier_tb.sv -----
module debounced_short_long_press_classifier_tb;
   import dslpc_pkg::*;

   localparam int COUNT_BITS = COUNT_BITS_DEFAULT;
   localparam int MAX_GAP = 18;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int QUIET_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int RANDOM_PHASES = 6;
   localparam int PRINT_LIMIT = 40;

   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_raw_level = 1'b1;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_event_kind;
   logic [COLUMN_BITS-1:0]    rsp_column_number;
   logic [COLUMN_BITS-1:0]    rsp_color_index;
   logic                      rsp_led_level;
   logic                      rsp_debounced_level;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_DEBOUNCE_TICKS;
   logic [CFG_BITS-1:0]       csr_data = '0;

   debounced_short_long_press_classifier DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_level       (req_raw_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_column_number   (rsp_column_number),
      .rsp_color_index     (rsp_color_index),
      .rsp_led_level       (rsp_led_level),
      .rsp_debounced_level (rsp_debounced_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial forever #6 clock = ~clock;

   // Shadow copy of the switch state and the registers.
   logic [CFG_BITS-1:0]    debounce_cfg = DEBOUNCE_TICKS_RESET;
   logic [CFG_BITS-1:0]    long_press_cfg = LONG_PRESS_TICKS_RESET;
   logic                   last_raw = 1'b1;
   logic                   settled_level = 1'b1;
   logic [COUNT_BITS-1:0]  settle_count = '0;
   logic [COUNT_BITS-1:0]  hold_count = '0;
   logic                   long_reported = 1'b0;
   logic [COLUMN_BITS-1:0] short_col = SHORT_COLUMN_RESET;
   logic [COLUMN_BITS-1:0] long_col = LONG_COLUMN_RESET;
   logic                   led_on = 1'b0;

   result_type tick_results_due[$];
   int         error_count = 0;
   int         ticks_sent = 0;
   bit         sender_gaps_on = 1'b1;
   bit         receiver_gaps_on = 1'b1;
   bit         hold_request = 1'b0;

   // Advance the switch state by one tick and return the classification.
   function automatic result_type classify_tick(input logic raw);
      result_type r;
      r = '0;
      r.event_kind = EV_NONE;
      if (raw != last_raw) begin
         settle_count = '0;
      end else if (settle_count != '1) begin
         settle_count = settle_count + 1'b1;
      end
      if (hold_count != '1) begin
         hold_count = hold_count + 1'b1;
      end

      // The debounced level moves only once the raw level has settled.
      if (settle_count > debounce_cfg && raw != settled_level) begin
         settled_level = raw;
         if (!settled_level) begin
            hold_count = '0;
            long_reported = 1'b0;
         end else if (!long_reported && hold_count < long_press_cfg) begin
            r.event_kind = EV_SHORT;
            r.column_number = short_col;
            short_col[0] = ~short_col[0];
            r.color_index = short_col;
            led_on = 1'b1;
         end
      end

      // At most one long event per press.
      if (!settled_level && hold_count >= long_press_cfg && !long_reported) begin
         r.event_kind = EV_LONG;
         r.column_number = long_col;
         long_col[0] = ~long_col[0];
         r.color_index = long_col;
         led_on = 1'b0;
         long_reported = 1'b1;
      end

      last_raw = raw;
      r.led_level = led_on;
      r.debounced_level = settled_level;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   // Offer one tick item, after a random gap when sender gaps are on, and record its expected result.
   task automatic send_tick(input logic level);
      int unsigned gap;
      gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_level <= level;
      do @(posedge clock); while (!req_ready);
      tick_results_due.push_back(classify_tick(level));
      ticks_sent++;
   endtask

   task automatic send_run(input logic level, input int unsigned count);
      repeat (count) send_tick(level);
   endtask

   // Let every outstanding result come back so the block is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DEBOUNCE_TICKS:   debounce_cfg = data;
         CSR_LONG_PRESS_TICKS: long_press_cfg = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Two short presses and two long presses walk both columns through
   // their values; a long press is followed by a silent release.
   task automatic test_column_toggling();
      write_csr(CSR_DEBOUNCE_TICKS, 16'd0);
      write_csr(CSR_LONG_PRESS_TICKS, 16'd3);
      repeat (2) begin
         send_run(1'b0, 2);
         send_run(1'b1, 2);
      end
      repeat (2) begin
         send_run(1'b0, 5);
         send_run(1'b1, 2);
      end
      // Bouncing raw level never settles.
      repeat (2) begin
         send_tick(1'b0);
         send_tick(1'b1);
      end
   endtask

   task automatic test_spare_registers();
      wait_idle();
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, 16'h5A5A);
      send_run(1'b0, 4);
      send_run(1'b1, 4);
   endtask

   // The receiver stalls for a long stretch while ticks keep coming.
   task automatic test_back_pressure();
      sender_gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (30) send_tick(1'($urandom_range(0, 1)));
      sender_gaps_on = 1'b1;
   endtask

   // One press: some bounce, a low stretch, more bounce, a high stretch, or at times bounce alone.
   task automatic press_sequence();
      int unsigned settle;
      int unsigned press_span;
      settle = debounce_cfg;
      press_span = (long_press_cfg > 40) ? 40 : long_press_cfg;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
         send_run(1'b0, $urandom_range(1, settle + press_span + 6));
         repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
         send_run(1'b1, $urandom_range(1, settle + 6));
      end
   endtask

   task automatic test_random_presses();
      int phase_start;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_csr(CSR_DEBOUNCE_TICKS, DEBOUNCE_TICKS_RESET);
               write_csr(CSR_LONG_PRESS_TICKS, LONG_PRESS_TICKS_RESET);
            end
            1: begin
               write_csr(CSR_DEBOUNCE_TICKS, CFG_BITS'($urandom_range(0, 4)));
               write_csr(CSR_LONG_PRESS_TICKS, 16'd1);
            end
            default: begin
               write_csr(CSR_DEBOUNCE_TICKS, CFG_BITS'($urandom_range(0, 6)));
               write_csr(CSR_LONG_PRESS_TICKS, CFG_BITS'($urandom_range(2, 24)));
            end
         endcase
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         receiver_gaps_on = ($urandom_range(0, 3) != 0);
         phase_start = ticks_sent;
         while (ticks_sent < phase_start + ITEMS_PER_PHASE) press_sequence();
      end
      sender_gaps_on = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   // A ceiling debounce time is never exceeded, so a held level stays
   // released; dropping the time to zero then lets the held level fall.
   task automatic test_debounce_ceiling();
      wait_idle();
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      write_csr(CSR_DEBOUNCE_TICKS, '1);
      write_csr(CSR_LONG_PRESS_TICKS, '1);
      send_run(1'b1, 4);
      send_run(1'b0, 20);
      wait_idle();
      write_csr(CSR_DEBOUNCE_TICKS, 16'd0);
      send_run(1'b0, 2);
      send_run(1'b1, 3);
      sender_gaps_on = 1'b1;
      receiver_gaps_on = 1'b1;
   endtask

   // Result side: random stalls per item when enabled, plus one long hold-off on request.
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = receiver_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare every accepted result item with the oldest expectation.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_results_due.size() == 0) begin
            report_mismatch("result item with no tick outstanding");
         end else begin
            want = tick_results_due.pop_front();
            check_field("event_kind", rsp_event_kind, want.event_kind);
            check_field("column_number", rsp_column_number, want.column_number);
            check_field("color_index", rsp_color_index, want.color_index);
            check_field("led_level", rsp_led_level, want.led_level);
            check_field("debounced_level", rsp_debounced_level, want.debounced_level);
         end
      end
   end

   // End the run if no channel moves for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_column_toggling();
      test_spare_registers();
      test_back_pressure();
      test_random_presses();
      test_debounce_ceiling();
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
